// File: rtl/ciqs_pkg.sv
// Package: shared types and constants of the searchable ring-buffer queue.
`timescale 1ns / 1ps

package ciqs_pkg;

  localparam int DEPTH  = 256;
  localparam int WORD_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_ENQUEUE = 3'd0,
    KIND_DEQUEUE = 3'd1,
    KIND_PEEK    = 3'd2,
    KIND_CLEAR   = 3'd3,
    KIND_SEARCH  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [WORD_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    status_t                  status;
    logic signed [WORD_W-1:0] data;
    logic [ADDR_W-1:0]        position;
    logic [CNT_W-1:0]         occupancy;
    logic                     empty_flag;
    logic                     full_flag;
  } out_word_t;

  // engine status toward the channel logic
  typedef struct packed {
    logic idle;
    logic done;
  } eng_stat_t;

endpackage

// File: rtl/ciqs_engine.sv
// Queue engine: slot memory, head/tail/count and the dequeue and search sequencer.
`timescale 1ns / 1ps

module ciqs_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ciqs_pkg::in_word_t   item,
  input  logic [ciqs_pkg::CNT_W-1:0] cap,
  input  logic                 out_free,
  output ciqs_pkg::eng_stat_t  ctl,
  output ciqs_pkg::out_word_t  res
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_SRED = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  function automatic logic [ciqs_pkg::ADDR_W-1:0] adv(
    input logic [ciqs_pkg::ADDR_W-1:0] idx,
    input logic [ciqs_pkg::CNT_W-1:0]  lim
  );
    logic [ciqs_pkg::CNT_W-1:0] nxt;
    nxt = {1'b0, idx} + ciqs_pkg::CNT_W'(1);
    return (nxt >= lim) ? '0 : nxt[ciqs_pkg::ADDR_W-1:0];
  endfunction

  logic [ciqs_pkg::WORD_W-1:0] mem [ciqs_pkg::DEPTH];
  logic [ciqs_pkg::WORD_W-1:0] rdata;

  state_t                        state;
  logic [ciqs_pkg::ADDR_W-1:0]   head;
  logic [ciqs_pkg::ADDR_W-1:0]   tail;
  logic [ciqs_pkg::CNT_W-1:0]    count;
  logic [ciqs_pkg::WORD_W-1:0]   key;
  logic [ciqs_pkg::ADDR_W-1:0]   scan_slot;
  logic [ciqs_pkg::ADDR_W-1:0]   cmp_slot;
  logic                          cmp_valid;
  logic [ciqs_pkg::CNT_W-1:0]    remaining;
  ciqs_pkg::status_t             res_status;
  logic [ciqs_pkg::WORD_W-1:0]   res_data;
  logic [ciqs_pkg::ADDR_W-1:0]   res_pos;

  logic                          is_full;
  logic                          is_empty;
  logic                          go_read;
  logic                          go_search;
  logic                          imm;
  ciqs_pkg::status_t             imm_status;
  logic [ciqs_pkg::CNT_W-1:0]    count_next;
  logic                          wr_en;
  logic                          rd_en;
  logic [ciqs_pkg::ADDR_W-1:0]   rd_addr;
  logic                          hit;
  logic                          scan_issue;

  assign is_full  = (count >= cap);
  assign is_empty = (count == '0);
  assign hit      = cmp_valid && (rdata == key);

  always_comb begin
    imm_status = ciqs_pkg::STATUS_OK;
    count_next = count;
    go_read    = 1'b0;
    go_search  = 1'b0;
    wr_en      = 1'b0;
    unique case (item.kind)
      ciqs_pkg::KIND_ENQUEUE: begin
        if (is_full) begin
          imm_status = ciqs_pkg::STATUS_FULL;
        end else begin
          wr_en      = start;
          count_next = count + ciqs_pkg::CNT_W'(1);
        end
      end
      ciqs_pkg::KIND_DEQUEUE, ciqs_pkg::KIND_PEEK: begin
        if (is_empty) begin
          imm_status = ciqs_pkg::STATUS_EMPTY;
        end else begin
          go_read = 1'b1;
          if (item.kind == ciqs_pkg::KIND_DEQUEUE) begin
            count_next = count - ciqs_pkg::CNT_W'(1);
          end
        end
      end
      ciqs_pkg::KIND_CLEAR: begin
        count_next = '0;
      end
      ciqs_pkg::KIND_SEARCH: begin
        if (is_empty) begin
          imm_status = ciqs_pkg::STATUS_NOT_FOUND;
        end else begin
          go_search = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign imm        = start && !go_read && !go_search;
  assign scan_issue = (state == ST_SCAN) && !hit && (remaining != '0);
  assign rd_en      = (start && go_read) || scan_issue;
  assign rd_addr    = (state == ST_SCAN) ? scan_slot : head;

  // One item at a time: an enqueue write always lands before any later read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= item.value;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      cmp_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            count <= count_next;
            unique case (item.kind)
              ciqs_pkg::KIND_ENQUEUE: begin
                if (!is_full) begin
                  tail <= adv(tail, cap);
                end
              end
              ciqs_pkg::KIND_DEQUEUE: begin
                if (!is_empty) begin
                  head  <= adv(head, cap);
                  state <= ST_READ;
                end
              end
              ciqs_pkg::KIND_PEEK: begin
                if (!is_empty) begin
                  state <= ST_READ;
                end
              end
              ciqs_pkg::KIND_CLEAR: begin
                head <= '0;
                tail <= '0;
              end
              ciqs_pkg::KIND_SEARCH: begin
                if (!is_empty) begin
                  state <= ST_SRED;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_READ: begin
          state <= ST_RESP;
        end
        ST_SRED: begin
          // head mod capacity, one subtract per cycle
          if ({1'b0, scan_slot} < cap) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit || (remaining == '0)) begin
            cmp_valid <= 1'b0;
            state     <= ST_RESP;
          end else begin
            cmp_valid <= 1'b1;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start && go_search) begin
      key       <= item.value;
      scan_slot <= head;
      remaining <= count;
    end
    if (state == ST_SRED && {1'b0, scan_slot} >= cap) begin
      scan_slot <= scan_slot - cap[ciqs_pkg::ADDR_W-1:0];
    end
    if (scan_issue) begin
      cmp_slot  <= scan_slot;
      scan_slot <= adv(scan_slot, cap);
      remaining <= remaining - ciqs_pkg::CNT_W'(1);
    end
    if (state == ST_READ) begin
      res_status <= ciqs_pkg::STATUS_OK;
      res_data   <= rdata;
      res_pos    <= '0;
    end
    if (state == ST_SCAN) begin
      res_data <= '0;
      if (hit) begin
        res_status <= ciqs_pkg::STATUS_OK;
        res_pos    <= cmp_slot;
      end else begin
        res_status <= ciqs_pkg::STATUS_NOT_FOUND;
        res_pos    <= '0;
      end
    end
  end

  always_comb begin
    if (state == ST_IDLE) begin
      res.status     = imm_status;
      res.data       = '0;
      res.position   = '0;
      res.occupancy  = count_next;
      res.empty_flag = (count_next == '0);
      res.full_flag  = (count_next >= cap);
    end else begin
      res.status     = res_status;
      res.data       = res_data;
      res.position   = res_pos;
      res.occupancy  = count;
      res.empty_flag = is_empty;
      res.full_flag  = is_full;
    end
  end

  assign ctl.idle = (state == ST_IDLE);
  assign ctl.done = ((state == ST_IDLE) && imm) || ((state == ST_RESP) && out_free);

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("memory write and read in the same cycle");
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    ctl.done |-> out_free)
    else $error("result finished while output register busy");
  a_read_resp: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_RESP))
    else $error("dequeue read did not complete");
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (remaining <= count))
    else $error("search scan beyond stored words");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> (state == ST_IDLE))
    else $error("word accepted while engine busy");
`endif

endmodule

// File: rtl/circular_int_queue_with_search.sv
// Top level: searchable ring-buffer queue with capacity register and output register.
// Output not stalled: enqueue, clear, unused kinds, and dequeue/peek/search on an empty queue:
//   result valid the cycle after accept. Dequeue/peek: one memory read (ST_READ), then ST_RESP.
// Search: head reduced mod capacity (ST_SRED), then at most occupancy slots compared (ST_SCAN).
// Throughput: 1 enqueue per cycle unless output stalls; next word taken once last result loads.
// Reset (sync): head, tail, count cleared, capacity 256; memory contents undefined, no clear pass.
`timescale 1ns / 1ps

module circular_int_queue_with_search (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_stall,
  input  ciqs_pkg::in_word_t          item,
  output logic                        result_valid,
  input  logic                        result_stall,
  output ciqs_pkg::out_word_t         result,
  input  logic                        cfg_we,
  input  logic [ciqs_pkg::CNT_W-1:0]  cfg_data
);

  logic [ciqs_pkg::CNT_W-1:0] cap;
  logic                       out_free;
  logic                       start;
  ciqs_pkg::eng_stat_t        ctl;
  ciqs_pkg::out_word_t        res;

  // zero acts as one, anything above the memory depth as the depth
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= ciqs_pkg::CNT_W'(ciqs_pkg::DEPTH);
    end else if (cfg_we) begin
      if (cfg_data == '0) begin
        cap <= ciqs_pkg::CNT_W'(1);
      end else if (cfg_data > ciqs_pkg::CNT_W'(ciqs_pkg::DEPTH)) begin
        cap <= ciqs_pkg::CNT_W'(ciqs_pkg::DEPTH);
      end else begin
        cap <= cfg_data;
      end
    end
  end

  assign out_free   = !result_valid || !result_stall;
  assign item_stall = !(ctl.idle && out_free);
  assign start      = item_valid && !item_stall;

  ciqs_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .item     (item),
    .cap      (cap),
    .out_free (out_free),
    .ctl      (ctl),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.done) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) begin
      result <= res;
    end
  end

endmodule

// File: tb/ciqs_check.sv
// Checker: watches both channels and the capacity port, models the queue and compares results.
`timescale 1ns / 1ps

module ciqs_check (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  input  logic                        item_stall,
  input  ciqs_pkg::in_word_t          item,
  input  logic                        result_valid,
  input  logic                        result_stall,
  input  ciqs_pkg::out_word_t         result,
  input  logic                        cfg_we,
  input  logic [ciqs_pkg::CNT_W-1:0]  cfg_data,
  output int                          outcomes_waiting,
  output int                          mismatch_count
);
  import ciqs_pkg::*;

  localparam int PRINT_LIMIT = 40;

  // private copy of the queue
  logic signed [WORD_W-1:0] slot_copy [DEPTH];
  logic [ADDR_W-1:0]        head_pos;
  logic [ADDR_W-1:0]        tail_pos;
  logic [CNT_W-1:0]         word_count;
  logic [CNT_W-1:0]         capacity_reg;
  out_word_t                outcome_fifo [$];

  // register value 0 behaves as 1, anything past DEPTH as DEPTH
  function automatic int usable_slots(input logic [CNT_W-1:0] r);
    if (r == '0) return 1;
    if (r > DEPTH) return DEPTH;
    return int'(r);
  endfunction

  function automatic logic [ADDR_W-1:0] next_slot(input int idx, input int cap);
    return (idx + 1 >= cap) ? '0 : ADDR_W'(idx + 1);
  endfunction

  function automatic out_word_t queue_op_outcome(input in_word_t w);
    out_word_t o;
    int        cap;
    int        slot;
    int        i;
    cap = usable_slots(capacity_reg);
    o = '0;
    case (w.kind)
      KIND_ENQUEUE: begin
        if (word_count >= cap) begin
          o.status = STATUS_FULL;
        end else begin
          slot_copy[tail_pos] = w.value;
          tail_pos = next_slot(int'(tail_pos), cap);
          word_count = word_count + 1'b1;
        end
      end
      KIND_DEQUEUE, KIND_PEEK: begin
        if (word_count == '0) begin
          o.status = STATUS_EMPTY;
        end else begin
          o.data = slot_copy[head_pos];
          if (w.kind == KIND_DEQUEUE) begin
            head_pos = next_slot(int'(head_pos), cap);
            word_count = word_count - 1'b1;
          end
        end
      end
      KIND_CLEAR: begin
        head_pos = '0;
        tail_pos = '0;
        word_count = '0;
      end
      KIND_SEARCH: begin
        // oldest to newest; slots wrap on the capacity in use, not on DEPTH
        o.status = STATUS_NOT_FOUND;
        for (i = 0; i < word_count; i++) begin
          slot = (int'(head_pos) + i) % cap;
          if (slot_copy[slot] == w.value) begin
            o.status = STATUS_OK;
            o.position = ADDR_W'(slot);
            break;
          end
        end
      end
      default: ;
    endcase
    o.occupancy = word_count;
    o.empty_flag = (word_count == '0);
    o.full_flag = (word_count >= cap);
    return o;
  endfunction

  task automatic report_mismatch(input string what, input out_word_t want, input out_word_t got);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("[%0t] mismatch, %s: want st=%0d data=%h pos=%0d occ=%0d e=%b f=%b, got st=%0d data=%h pos=%0d occ=%0d e=%b f=%b",
               $time, what, want.status, want.data, want.position, want.occupancy,
               want.empty_flag, want.full_flag, got.status, got.data, got.position,
               got.occupancy, got.empty_flag, got.full_flag);
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    if (rst) begin
      head_pos = '0;
      tail_pos = '0;
      word_count = '0;
      capacity_reg = CNT_W'(DEPTH);
      outcome_fifo.delete();
    end else begin
      if (cfg_we) capacity_reg = cfg_data;
      if (result_valid && !result_stall) begin
        if (outcome_fifo.size() == 0) begin
          report_mismatch("result word with none outstanding", '0, result);
        end else begin
          want = outcome_fifo.pop_front();
          if (result !== want) report_mismatch("result word", want, result);
        end
      end
      if (item_valid && !item_stall) outcome_fifo.push_back(queue_op_outcome(item));
    end
    outcomes_waiting = outcome_fifo.size();
  end

endmodule

// File: tb/tb.sv
// Testbench top: clock, reset, stimulus and receiver stalls for the searchable ring-buffer queue.
`timescale 1ns / 1ps

module tb;
  import ciqs_pkg::*;

  localparam int ITEM_TARGET   = 1800;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 20;
  localparam int RECENT_KEEP   = 16;

  localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  in_word_t         item;
  logic             result_valid;
  logic             result_stall;
  out_word_t        result;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;

  int  outcomes_waiting;
  int  mismatch_count;
  int  sent_count;
  int  burst_left;
  bit  hold_req;
  logic signed [WORD_W-1:0] recent_words [$];

  circular_int_queue_with_search u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  ciqs_check u_check (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_valid),
    .item_stall       (item_stall),
    .item             (item),
    .result_valid     (result_valid),
    .result_stall     (result_stall),
    .result           (result),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .outcomes_waiting (outcomes_waiting),
    .mismatch_count   (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic signed [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '1;
      3, 4: return WORD_W'($urandom_range(0, 7));  // narrow range so duplicates show up
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] rand_capacity();
    case ($urandom_range(0, 9))
      0: return CNT_W'(1);
      1: return '0;
      2: return CNT_W'(2);
      3: return CNT_W'(DEPTH);
      4: return '1;
      5: return CNT_W'($urandom_range(DEPTH + 1, (1 << CNT_W) - 1));
      6, 7: return CNT_W'($urandom_range(3, 16));
      default: return CNT_W'($urandom_range(17, DEPTH));
    endcase
  endfunction

  // offer one word, hold it until taken, then maybe open a gap
  task automatic send_word(input kind_t k, input logic signed [WORD_W-1:0] v);
    in_word_t w;
    int       gap;
    w.kind = k;
    w.value = v;
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(negedge clk); while (outcomes_waiting != 0);
    @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_op(input int enq_pct);
    kind_t                    k;
    logic signed [WORD_W-1:0] v;
    int                       pick;
    v = rand_word();
    if ($urandom_range(0, 99) < enq_pct) begin
      k = KIND_ENQUEUE;
      recent_words.push_back(v);
      if (recent_words.size() > RECENT_KEEP) void'(recent_words.pop_front());
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        k = KIND_DEQUEUE;
      end else if (pick < 60) begin
        k = KIND_PEEK;
      end else if (pick < 92) begin
        k = KIND_SEARCH;
        // mostly look for something that was stored lately
        if (recent_words.size() > 0 && $urandom_range(0, 9) < 6)
          v = recent_words[$urandom_range(0, recent_words.size() - 1)];
      end else if (pick < 96) begin
        k = KIND_CLEAR;
      end else begin
        k = kind_t'(3'(KIND_SEARCH + $urandom_range(1, 3)));
      end
    end
    send_word(k, v);
  endtask

  // receiver: stall patterns of random density, one long hold-off on request
  initial begin : stall_gen
    int mode_left;
    int stall_pct;
    mode_left = 0;
    stall_pct = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 200);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 20;
            2: stall_pct = 50;
            default: stall_pct = 85;
          endcase
        end
        mode_left--;
        result_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  initial begin : stim
    int  n_items;
    int  enq_pct;
    bit  first_phase;
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    sent_count = 0;
    burst_left = 0;
    hold_req = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue, then the unused kinds
    send_word(KIND_DEQUEUE, rand_word());
    send_word(KIND_PEEK, rand_word());
    send_word(KIND_SEARCH, '0);
    send_word(kind_t'(3'(KIND_SEARCH + 1)), rand_word());
    send_word(kind_t'(3'(KIND_SEARCH + 2)), rand_word());
    send_word(kind_t'(3'(KIND_SEARCH + 3)), rand_word());
    // extremes of the word
    send_word(KIND_ENQUEUE, WORD_MIN);
    send_word(KIND_ENQUEUE, WORD_MAX);
    send_word(KIND_ENQUEUE, '1);
    send_word(KIND_PEEK, '0);
    send_word(KIND_SEARCH, WORD_MAX);
    send_word(KIND_DEQUEUE, '0);
    // register 0 acts as a single slot
    write_capacity('0);
    send_word(KIND_CLEAR, '0);
    send_word(KIND_ENQUEUE, 32'sd5);
    send_word(KIND_ENQUEUE, 32'sd6);
    // above DEPTH acts as DEPTH
    write_capacity('1);
    send_word(KIND_CLEAR, '0);
    send_word(KIND_ENQUEUE, 32'sd7);
    // fill three, then shrink to two without a clear
    write_capacity(CNT_W'(3));
    send_word(KIND_CLEAR, '0);
    send_word(KIND_ENQUEUE, 32'sd11);
    send_word(KIND_ENQUEUE, 32'sd22);
    send_word(KIND_ENQUEUE, 32'sd33);
    send_word(KIND_ENQUEUE, 32'sd44);
    write_capacity(CNT_W'(2));
    send_word(KIND_DEQUEUE, '0);
    send_word(KIND_SEARCH, 32'sd33);
    send_word(KIND_DEQUEUE, '0);
    send_word(KIND_DEQUEUE, '0);

    // write every slot once so later capacity changes without a clear stay on written slots
    write_capacity(CNT_W'(DEPTH));
    send_word(KIND_CLEAR, rand_word());
    repeat (DEPTH) send_word(KIND_ENQUEUE, rand_word());

    first_phase = 1'b1;
    while (sent_count < ITEM_TARGET) begin
      write_capacity(rand_capacity());
      if ($urandom_range(0, 4) != 0) send_word(KIND_CLEAR, rand_word());
      n_items = $urandom_range(60, 200);
      case ($urandom_range(0, 2))
        0: enq_pct = 70;
        1: enq_pct = 50;
        default: enq_pct = 30;
      endcase
      if (first_phase) begin
        // receiver holds off while the sender keeps offering back to back
        hold_req = 1'b1;
        burst_left = HOLD_CYCLES + 100;
        first_phase = 1'b0;
      end
      repeat (n_items) send_random_op(enq_pct);
    end

    wait_drained();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
